[design/least_slack_task_scheduler_unit_defines.svh]
// assertion macros used by the scheduler unit
`ifndef LEAST_SLACK_TASK_SCHEDULER_UNIT_DEFINES_SVH
`define LEAST_SLACK_TASK_SCHEDULER_UNIT_DEFINES_SVH

// implication checked on every clock edge outside reset
`define LSTS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// implication checked on every clock edge, reset included
`define LSTS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/lsts_pkg.sv]
package lsts_pkg;

   localparam int MaxTasksDefault   = 16;
   localparam int QueueDepthDefault = 32;
   localparam int TimeBitsDefault   = 16;

   localparam logic OpLoad = 1'b0;
   localparam logic OpTick = 1'b1;

   typedef struct packed {
      logic        operation;
      logic [3:0]  task_index;
      logic [15:0] first_release;
      logic [15:0] work_units;
      logic [15:0] repeat_interval;
      logic [15:0] due_tick;
      logic [4:0]  predecessor;
   } req_word_type;

   typedef struct packed {
      logic [15:0] now_tick;
      logic        busy_res;
      logic [3:0]  running_task;
      logic        switched;
      logic        finished;
      logic        overflow;
   } rsp_word_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RELEASE,
      ST_MARK,
      ST_SELECT,
      ST_RUN,
      ST_SHIFT,
      ST_DONE
   } state_type;

endpackage

[design/least_slack_task_scheduler_unit.sv]
// channel | ports                            | direction
// request | start, busy, req_word            | in, accepted when start & !busy
// result  | rsp_valid, rsp_word              | out, one cycle strobe
//
// a load writes the task table in its done state and gives no result; a tick runs a release
// sweep over the task table, a mark sweep and a select sweep over the queue, a run state
// and, when the chosen job completes, a shift that moves the jobs above it down the job cells;
// the result strobe follows the last busy cycle
// reset clears the task table, queue valid bits, time and previous job
// results cannot be stalled; busy stays high until the result strobe of a tick
`include "least_slack_task_scheduler_unit_defines.svh"

module least_slack_task_scheduler_unit #(
   parameter int MAX_TASKS   = lsts_pkg::MaxTasksDefault,
   parameter int QUEUE_DEPTH = lsts_pkg::QueueDepthDefault,
   parameter int TIME_BITS   = lsts_pkg::TimeBitsDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  lsts_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   output lsts_pkg::rsp_word_type rsp_word
);

   localparam int TB  = $clog2(MAX_TASKS);
   localparam int QB  = $clog2(QUEUE_DEPTH);
   localparam int CB  = $clog2(QUEUE_DEPTH + 1);
   localparam int SB  = TIME_BITS + 2;

   // task table
   logic [TIME_BITS-1:0] t_rel_ff [MAX_TASKS];
   logic [TIME_BITS-1:0] t_work_ff [MAX_TASKS];
   logic [TIME_BITS-1:0] t_int_ff [MAX_TASKS];
   logic [TIME_BITS-1:0] t_due_ff [MAX_TASKS];
   logic [4:0]           t_pred_ff [MAX_TASKS];
   logic [MAX_TASKS-1:0] t_pend_ff;

   lsts_pkg::state_type state_ff, state_in;
   lsts_pkg::req_word_type req_ff;
   logic [TIME_BITS-1:0] now_ff;
   logic [TB:0]          tidx_ff, tidx_in;
   logic [CB-1:0]        qidx_ff, qidx_in;
   logic [CB-1:0]        count_ff;
   logic                 ovf_ff;
   logic [MAX_TASKS-1:0] queued_ff;
   logic                 best_ok_ff;
   logic [QB-1:0]        best_ff;
   logic signed [SB-1:0] best_slack_ff;
   logic [TB-1:0]        best_task_ff;
   logic                 prev_ok_ff;
   logic [QB-1:0]        prev_ff;
   lsts_pkg::rsp_word_type rsp_ff;
   logic                 rsp_valid_ff;
   logic                 fin_ff;

   // job cell chain
   logic                 c_valid [QUEUE_DEPTH];
   logic [TB-1:0]        c_task [QUEUE_DEPTH];
   logic [TIME_BITS-1:0] c_left [QUEUE_DEPTH];
   logic [TIME_BITS-1:0] c_due [QUEUE_DEPTH];
   logic                 rel_push;
   logic [TIME_BITS-1:0] rel_due, rel_left;
   logic [TB-1:0]        cur_t;
   logic                 cur_ok;

   assign cur_t  = tidx_ff[TB-1:0];
   assign cur_ok = (tidx_ff < (TB+1)'(MAX_TASKS));
   assign rel_push = (state_ff == lsts_pkg::ST_RELEASE) && cur_ok && t_pend_ff[cur_t]
                     && (t_rel_ff[cur_t] <= now_ff);
   assign rel_due  = (t_int_ff[cur_t] == '0) ? t_due_ff[cur_t]
                     : t_rel_ff[cur_t] + t_int_ff[cur_t];
   assign rel_left = (t_work_ff[cur_t] == '0) ? TIME_BITS'(1) : t_work_ff[cur_t];

   for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      logic                 nv;
      logic [TB-1:0]        nt;
      logic [TIME_BITS-1:0] nl, nd;
      if (g == QUEUE_DEPTH - 1) begin : g_last
         assign nv = 1'b0;
         assign nt = '0;
         assign nl = '0;
         assign nd = '0;
      end else begin : g_mid
         assign nv = c_valid[g+1];
         assign nt = c_task[g+1];
         assign nl = c_left[g+1];
         assign nd = c_due[g+1];
      end
      lsts_job_cell #(.TaskBits(TB), .TimeBits(TIME_BITS)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .load_en   (rel_push && count_ff == CB'(g)),
         .load_task (cur_t),
         .load_left (rel_left),
         .load_due  (rel_due),
         .dec_en    (state_ff == lsts_pkg::ST_RUN && best_ok_ff && best_ff == QB'(g)),
         .shift_en  (state_ff == lsts_pkg::ST_SHIFT && qidx_ff[QB-1:0] == QB'(g)
                     && qidx_ff < CB'(QUEUE_DEPTH)),
         .next_valid(nv),
         .next_task (nt),
         .next_left (nl),
         .next_due  (nd),
         .clear_en  (1'b0),
         .valid     (c_valid[g]),
         .task_id   (c_task[g]),
         .left      (c_left[g]),
         .due       (c_due[g])
      );
   end

   // scan view of the current queue slot
   logic [QB-1:0]        qi;
   logic                 q_in;
   logic [TB-1:0]        q_task;
   logic [4:0]           q_pred;
   logic                 q_elig;
   logic signed [SB-1:0] q_slack;
   logic                 q_better;
   assign qi     = qidx_ff[QB-1:0];
   assign q_in   = qidx_ff < count_ff;
   assign q_task = c_task[qi];
   assign q_pred = t_pred_ff[q_task];
   assign q_elig = !(q_pred < 5'(MAX_TASKS) && queued_ff[q_pred[TB-1:0]]);
   assign q_slack = $signed({2'b00, c_due[qi]}) - $signed({2'b00, now_ff})
                    - $signed({2'b00, c_left[qi]});
   assign q_better = !best_ok_ff || q_slack < best_slack_ff
                     || (q_slack == best_slack_ff && q_task < best_task_ff);

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      tidx_in  = tidx_ff;
      qidx_in  = qidx_ff;
      unique case (state_ff)
         lsts_pkg::ST_IDLE: begin
            if (start) begin
               state_in = (req_word.operation == lsts_pkg::OpTick)
                          ? lsts_pkg::ST_RELEASE : lsts_pkg::ST_DONE;
               tidx_in = '0;
            end
         end
         lsts_pkg::ST_RELEASE: begin
            tidx_in = tidx_ff + 1'b1;
            qidx_in = '0;
            if (tidx_ff == (TB+1)'(MAX_TASKS - 1)) state_in = lsts_pkg::ST_MARK;
         end
         lsts_pkg::ST_MARK: begin
            qidx_in = qidx_ff + 1'b1;
            if (!q_in) begin
               qidx_in  = '0;
               state_in = lsts_pkg::ST_SELECT;
            end
         end
         lsts_pkg::ST_SELECT: begin
            qidx_in = qidx_ff + 1'b1;
            if (!q_in) state_in = lsts_pkg::ST_RUN;
         end
         lsts_pkg::ST_RUN: begin
            qidx_in  = {1'b0, best_ff};
            state_in = (best_ok_ff && c_left[best_ff] == TIME_BITS'(1))
                       ? lsts_pkg::ST_SHIFT : lsts_pkg::ST_DONE;
         end
         lsts_pkg::ST_SHIFT: begin
            qidx_in = qidx_ff + 1'b1;
            if (qidx_ff + 1'b1 >= count_ff) state_in = lsts_pkg::ST_DONE;
         end
         lsts_pkg::ST_DONE: state_in = lsts_pkg::ST_IDLE;
         default: state_in = lsts_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lsts_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         t_pend_ff    <= '0;
         now_ff       <= '0;
         count_ff     <= '0;
         prev_ok_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_TASKS; i++) begin
            t_rel_ff[i]  <= '0;
            t_work_ff[i] <= '0;
            t_int_ff[i]  <= '0;
            t_due_ff[i]  <= '0;
            t_pred_ff[i] <= 5'd16;
         end
      end else begin
         rsp_valid_ff <= 1'b0;
         tidx_ff <= tidx_in;
         qidx_ff <= qidx_in;
         unique case (state_ff)
            lsts_pkg::ST_IDLE: begin
               if (start) begin
                  req_ff <= req_word;
                  ovf_ff <= 1'b0;
                  best_ok_ff <= 1'b0;
                  queued_ff <= '0;
                  fin_ff <= 1'b0;
               end
            end
            lsts_pkg::ST_RELEASE: begin
               if (cur_ok && t_pend_ff[cur_t] && t_rel_ff[cur_t] <= now_ff) begin
                  if (t_int_ff[cur_t] == '0) t_pend_ff[cur_t] <= 1'b0;
                  else t_rel_ff[cur_t] <= rel_due;
                  if (count_ff < CB'(QUEUE_DEPTH)) count_ff <= count_ff + 1'b1;
                  else ovf_ff <= 1'b1;
               end
            end
            lsts_pkg::ST_MARK: begin
               if (q_in) queued_ff[q_task] <= 1'b1;
            end
            lsts_pkg::ST_SELECT: begin
               if (q_in && q_elig && q_better) begin
                  best_ok_ff    <= 1'b1;
                  best_ff       <= qi;
                  best_slack_ff <= q_slack;
                  best_task_ff  <= q_task;
               end
            end
            lsts_pkg::ST_RUN: begin
               if (best_ok_ff && c_left[best_ff] == TIME_BITS'(1)) begin
                  fin_ff     <= 1'b1;
                  count_ff   <= count_ff - 1'b1;
                  prev_ok_ff <= 1'b0;
               end else begin
                  prev_ok_ff <= best_ok_ff;
               end
               prev_ff <= best_ff;
               rsp_ff.switched <= best_ok_ff && !(prev_ok_ff && prev_ff == best_ff);
            end
            lsts_pkg::ST_SHIFT: ;
            lsts_pkg::ST_DONE: begin
               if (req_ff.operation == lsts_pkg::OpLoad) begin
                  if (32'(req_ff.task_index) < MAX_TASKS) begin
                     t_rel_ff[req_ff.task_index[TB-1:0]]  <= TIME_BITS'(req_ff.first_release);
                     t_work_ff[req_ff.task_index[TB-1:0]] <= TIME_BITS'(req_ff.work_units);
                     t_int_ff[req_ff.task_index[TB-1:0]]  <= TIME_BITS'(req_ff.repeat_interval);
                     t_due_ff[req_ff.task_index[TB-1:0]]  <= TIME_BITS'(req_ff.due_tick);
                     t_pred_ff[req_ff.task_index[TB-1:0]] <= req_ff.predecessor;
                     t_pend_ff[req_ff.task_index[TB-1:0]] <= 1'b1;
                  end
               end else begin
                  rsp_valid_ff          <= 1'b1;
                  rsp_ff.now_tick       <= 16'(now_ff);
                  rsp_ff.busy_res       <= best_ok_ff;
                  rsp_ff.running_task   <= best_ok_ff ? 4'(best_task_ff) : 4'd0;
                  rsp_ff.finished       <= fin_ff;
                  rsp_ff.overflow       <= ovf_ff;
                  now_ff                <= now_ff + TIME_BITS'(1);
               end
            end
            default: ;
         endcase
      end
   end

   assign busy      = state_ff != lsts_pkg::ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   `LSTS_ASSERT(a_no_strobe_busy, clock, reset, rsp_valid |-> !busy, "result while busy")
   `LSTS_ASSERT(a_count_bound, clock, reset, count_ff <= CB'(QUEUE_DEPTH), "queue count high")
   `LSTS_ASSERT(a_finish_busy, clock, reset, rsp_valid && rsp_word.finished |-> rsp_word.busy_res, "finish idle")
   `LSTS_ASSERT(a_start_take, clock, reset, start && !busy |=> busy, "start ignored")

endmodule

[design/lsts_job_cell.sv]
// one queue slot: holds a job, shifts down toward slot 0 on removal
module lsts_job_cell #(
   parameter int TaskBits = 4,
   parameter int TimeBits = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                load_en,
   input  logic [TaskBits-1:0] load_task,
   input  logic [TimeBits-1:0] load_left,
   input  logic [TimeBits-1:0] load_due,
   input  logic                dec_en,
   input  logic                shift_en,
   input  logic                next_valid,
   input  logic [TaskBits-1:0] next_task,
   input  logic [TimeBits-1:0] next_left,
   input  logic [TimeBits-1:0] next_due,
   input  logic                clear_en,
   output logic                valid,
   output logic [TaskBits-1:0] task_id,
   output logic [TimeBits-1:0] left,
   output logic [TimeBits-1:0] due
);

   logic                valid_ff, valid_in;
   logic [TaskBits-1:0] task_ff, task_in;
   logic [TimeBits-1:0] left_ff, left_in;
   logic [TimeBits-1:0] due_ff, due_in;

   // slot update: load, decrement, shift from neighbor, or clear
   always_comb begin
      valid_in = valid_ff;
      task_in  = task_ff;
      left_in  = left_ff;
      due_in   = due_ff;
      if (load_en) begin
         valid_in = 1'b1;
         task_in  = load_task;
         left_in  = load_left;
         due_in   = load_due;
      end else if (shift_en) begin
         valid_in = next_valid;
         task_in  = next_task;
         left_in  = next_left;
         due_in   = next_due;
      end else if (clear_en) begin
         valid_in = 1'b0;
      end else if (dec_en) begin
         left_in = left_ff - TimeBits'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      task_ff <= task_in;
      left_ff <= left_in;
      due_ff  <= due_in;
   end

   assign valid   = valid_ff;
   assign task_id = task_ff;
   assign left    = left_ff;
   assign due     = due_ff;

endmodule
